@@ hdl/ntp_pkg.sv @@
`default_nettype none
package ntp_pkg;

  // sizing
  localparam int MAX_ENEMIES = 64;
  localparam int COORD_W     = 16;
  localparam int COOL_W      = 8;
  localparam int SPEED_W     = 16;
  localparam int RANGE_W     = 17;
  localparam int VEL_W       = 17;
  localparam int DIST_W      = 17;
  localparam int INDEX_W     = 6;
  localparam int D2_W        = 34;
  localparam int CNT_W       = $clog2(MAX_ENEMIES + 1);

  // digit-serial datapath
  localparam int DIGIT_W     = 4;
  localparam int MUL_STEPS   = COORD_W / DIGIT_W;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int SQRT_STEPS  = D2_W / 2;
  localparam int DIV_STEPS   = PROD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int SQ_REM_W    = DIST_W + 2;

  // register port
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam logic [0:0] REG_MAX_SPEED    = 1'b0;
  localparam logic [0:0] REG_ENGAGE_RANGE = 1'b1;

endpackage
`default_nettype wire

@@ hdl/ntp_if.sv @@
`default_nettype none
// enemy entry channel
interface ntp_in_if import ntp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] own_x;
  logic [COORD_W-1:0] own_y;
  logic [COOL_W-1:0]  own_cooldown;
  logic [COORD_W-1:0] enemy_x;
  logic [COORD_W-1:0] enemy_y;
  logic               enemy_alive;
  logic               last_enemy;

  modport source (output valid, own_x, own_y, own_cooldown, enemy_x, enemy_y,
                  enemy_alive, last_enemy, input ready);
  modport sink   (input valid, own_x, own_y, own_cooldown, enemy_x, enemy_y,
                  enemy_alive, last_enemy, output ready);
endinterface

// decision result channel
interface ntp_out_if import ntp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VEL_W-1:0]  velocity_x;
  logic signed [VEL_W-1:0]  velocity_y;
  logic                     target_valid;
  logic                     nearest_found;
  logic [INDEX_W-1:0]       nearest_index;
  logic [DIST_W-1:0]        nearest_distance;
  logic [COORD_W-1:0]       echo_x;
  logic [COORD_W-1:0]       echo_y;

  modport source (output valid, velocity_x, velocity_y, target_valid, nearest_found,
                  nearest_index, nearest_distance, echo_x, echo_y, input ready);
  modport sink   (input valid, velocity_x, velocity_y, target_valid, nearest_found,
                  nearest_index, nearest_distance, echo_x, echo_y, output ready);
endinterface
`default_nettype wire

@@ hdl/nearest_target_pursuit_top.sv @@
`default_nettype none
// Channel   Dir  Word
// enemy     in   own_x, own_y, own_cooldown, enemy_x, enemy_y, enemy_alive, last_enemy
// result    out  velocity_x, velocity_y, target_valid, nearest_found, nearest_index,
//                nearest_distance, echo_x, echo_y
// apb       in   max_speed (0x0), engage_range (0x4)
//
// A dead or surplus entry is settled in the idle state; an alive entry is squared
// (radix-16 squaring of dx and dy in the shared shift-add multiplier, a digit a step,
// then the compare). The last entry adds 17 square-root steps (one root bit a cycle)
// and, when the distance is non-zero, a multiply and a divide per axis, one quotient
// bit a cycle, then the output register load. Reset is synchronous and clears the
// search and the registers. A stalled result only holds the block at that load.
module nearest_target_pursuit_top import ntp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  ntp_in_if.sink                 enemy,
  ntp_out_if.source              result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_LOAD = 3'd7;

  logic [2:0]          state;
  logic [STEP_W-1:0]   step;

  // configuration
  logic [SPEED_W-1:0]  max_speed;
  logic [RANGE_W-1:0]  engage_range;

  // search state
  logic [CNT_W-1:0]    entry_cnt;
  logic                best_found;
  logic [D2_W-1:0]     best_d2;
  logic [INDEX_W-1:0]  best_index;
  logic [COORD_W-1:0]  best_ax;
  logic [COORD_W-1:0]  best_ay;
  logic                best_sx;
  logic                best_sy;

  // current word
  logic                last_seen;
  logic [COOL_W-1:0]   cooldown;
  logic [COORD_W-1:0]  own_x;
  logic [COORD_W-1:0]  own_y;
  logic                cur_sx;
  logic                cur_sy;

  // shift-add multiplier: two lanes, digits taken MSB first
  logic [COORD_W-1:0]  mul_a;
  logic [COORD_W-1:0]  mul_b;
  logic [COORD_W-1:0]  mul_c;
  logic [COORD_W-1:0]  mul_d;
  logic [D2_W-1:0]     acc;
  logic [D2_W-1:0]     acc_next;
  logic [COORD_W+DIGIT_W-1:0] prod_a;
  logic [COORD_W+DIGIT_W-1:0] prod_c;

  // square root, two radicand bits a step
  logic [D2_W-1:0]     sq_v;
  logic [SQ_REM_W-1:0] sq_rem;
  logic [SQ_REM_W-1:0] sq_rem_next;
  logic [DIST_W-1:0]   root;
  logic [DIST_W-1:0]   root_next;
  logic [SQ_REM_W+1:0] sq_sh;
  logic [SQ_REM_W+1:0] sq_trial;
  logic                sq_take;

  // restoring divider by the distance
  logic [PROD_W-1:0]   dvd;
  logic [DIST_W-1:0]   div_rem;
  logic [DIST_W-1:0]   div_rem_next;
  logic [DIST_W:0]     div_sh;
  logic                div_take;
  logic [VEL_W-1:0]    quo;
  logic [VEL_W-1:0]    quo_next;
  logic                axis;
  logic [VEL_W-1:0]    vel_x;
  logic [VEL_W-1:0]    vel_y;

  // entry offsets
  logic [COORD_W:0]    dx;
  logic [COORD_W:0]    dy;
  logic [COORD_W-1:0]  ax;
  logic [COORD_W-1:0]  ay;
  logic                better;
  logic                take_in;
  logic                out_free;
  logic                cfg_wr;

  // output register
  logic                o_valid;
  logic [VEL_W-1:0]    o_vx;
  logic [VEL_W-1:0]    o_vy;
  logic                o_target;
  logic                o_found;
  logic [INDEX_W-1:0]  o_index;
  logic [DIST_W-1:0]   o_dist;
  logic [COORD_W-1:0]  o_ex;
  logic [COORD_W-1:0]  o_ey;

  assign enemy.ready = (state == S_IDLE);
  assign take_in     = enemy.valid && enemy.ready;
  assign out_free    = !o_valid || result.ready;

  assign result.valid            = o_valid;
  assign result.velocity_x       = o_vx;
  assign result.velocity_y       = o_vy;
  assign result.target_valid     = o_target;
  assign result.nearest_found    = o_found;
  assign result.nearest_index    = o_index;
  assign result.nearest_distance = o_dist;
  assign result.echo_x           = o_ex;
  assign result.echo_y           = o_ey;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[APB_AW-1])
      REG_MAX_SPEED:    prdata = APB_DW'(max_speed);
      REG_ENGAGE_RANGE: prdata = APB_DW'(engage_range);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed    <= '0;
      engage_range <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[APB_AW-1])
        REG_MAX_SPEED:    max_speed    <= pwdata[SPEED_W-1:0];
        REG_ENGAGE_RANGE: engage_range <= pwdata[RANGE_W-1:0];
        default:          ;
      endcase
    end
  end

  // absolute offsets of the incoming entry
  always_comb begin
    dx = {1'b0, enemy.enemy_x} - {1'b0, enemy.own_x};
    dy = {1'b0, enemy.enemy_y} - {1'b0, enemy.own_y};
    ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  end

  // one radix-16 digit per lane
  always_comb begin
    prod_a   = mul_a * mul_b[COORD_W-1 -: DIGIT_W];
    prod_c   = mul_c * mul_d[COORD_W-1 -: DIGIT_W];
    acc_next = {acc[D2_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + D2_W'(prod_a) + D2_W'(prod_c);
  end

  // root step
  always_comb begin
    sq_sh       = {sq_rem, sq_v[D2_W-1 -: 2]};
    sq_trial    = {2'b00, root, 2'b01};
    sq_take     = (sq_sh >= sq_trial);
    sq_rem_next = sq_take ? SQ_REM_W'(sq_sh - sq_trial) : SQ_REM_W'(sq_sh);
    root_next   = {root[DIST_W-2:0], sq_take};
  end

  // quotient step
  always_comb begin
    div_sh       = {div_rem, dvd[PROD_W-1]};
    div_take     = (div_sh >= {1'b0, root});
    div_rem_next = div_take ? DIST_W'(div_sh - {1'b0, root}) : DIST_W'(div_sh);
    quo_next     = {quo[VEL_W-2:0], div_take};
  end

  assign better = !best_found || (acc < best_d2);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      entry_cnt  <= '0;
      best_found <= 1'b0;
      best_d2    <= '1;
      best_index <= '0;
      o_valid    <= 1'b0;
    end else begin
      // the load below refills the register in its own cycle
      if (o_valid && result.ready && (state != S_LOAD)) o_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (take_in) begin
            last_seen <= enemy.last_enemy;
            cooldown  <= enemy.own_cooldown;
            own_x     <= enemy.own_x;
            own_y     <= enemy.own_y;
            if (entry_cnt < CNT_W'(MAX_ENEMIES) && enemy.enemy_alive) begin
              mul_a  <= ax;
              mul_b  <= ax;
              mul_c  <= ay;
              mul_d  <= ay;
              cur_sx <= dx[COORD_W];
              cur_sy <= dy[COORD_W];
              acc    <= '0;
              step   <= '0;
              state  <= S_SQ;
            end else begin
              if (entry_cnt < CNT_W'(MAX_ENEMIES)) entry_cnt <= entry_cnt + 1'b1;
              if (enemy.last_enemy) state <= S_FIN;
            end
          end
        end

        S_SQ: begin
          acc   <= acc_next;
          mul_b <= mul_b << DIGIT_W;
          mul_d <= mul_d << DIGIT_W;
          step  <= step + 1'b1;
          if (step == STEP_W'(MUL_STEPS - 1)) state <= S_CMP;
        end

        S_CMP: begin
          if (better) begin
            best_found <= 1'b1;
            best_d2    <= acc;
            best_index <= entry_cnt[INDEX_W-1:0];
            best_ax    <= mul_a;
            best_ay    <= mul_c;
            best_sx    <= cur_sx;
            best_sy    <= cur_sy;
          end
          entry_cnt <= entry_cnt + 1'b1;
          state     <= last_seen ? S_FIN : S_IDLE;
        end

        S_FIN: begin
          sq_v   <= best_d2;
          sq_rem <= '0;
          root   <= '0;
          step   <= '0;
          vel_x  <= '0;
          vel_y  <= '0;
          state  <= best_found ? S_SQRT : S_LOAD;
        end

        S_SQRT: begin
          sq_v   <= sq_v << 2;
          sq_rem <= sq_rem_next;
          root   <= root_next;
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            step <= '0;
            // zero distance leaves the velocity at zero
            if (root_next == '0) begin
              state <= S_LOAD;
            end else begin
              mul_a <= best_ax;
              mul_b <= COORD_W'(max_speed);
              mul_c <= '0;
              mul_d <= '0;
              acc   <= '0;
              axis  <= 1'b0;
              state <= S_MUL;
            end
          end else begin
            step <= step + 1'b1;
          end
        end

        S_MUL: begin
          acc   <= acc_next;
          mul_b <= mul_b << DIGIT_W;
          mul_d <= mul_d << DIGIT_W;
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            dvd     <= acc_next[PROD_W-1:0];
            div_rem <= '0;
            quo     <= '0;
            step    <= '0;
            state   <= S_DIV;
          end else begin
            step <= step + 1'b1;
          end
        end

        S_DIV: begin
          dvd     <= dvd << 1;
          div_rem <= div_rem_next;
          quo     <= quo_next;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step <= '0;
            if (!axis) begin
              vel_x <= best_sx ? VEL_W'(-quo_next) : quo_next;
              mul_a <= best_ay;
              mul_b <= COORD_W'(max_speed);
              mul_c <= '0;
              mul_d <= '0;
              acc   <= '0;
              axis  <= 1'b1;
              state <= S_MUL;
            end else begin
              vel_y <= best_sy ? VEL_W'(-quo_next) : quo_next;
              state <= S_LOAD;
            end
          end else begin
            step <= step + 1'b1;
          end
        end

        S_LOAD: begin
          if (out_free) begin
            o_valid  <= 1'b1;
            o_vx     <= best_found ? vel_x : '0;
            o_vy     <= best_found ? vel_y : '0;
            o_target <= best_found && (RANGE_W'(root) <= engage_range) && (cooldown == '0);
            o_found  <= best_found;
            o_index  <= best_found ? best_index : '0;
            o_dist   <= best_found ? root : '1;
            o_ex     <= own_x;
            o_ey     <= own_y;
            // fresh search for the next decision
            entry_cnt  <= '0;
            best_found <= 1'b0;
            best_d2    <= '1;
            best_index <= '0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ tb/nearest_target_pursuit_top_test.sv @@
`default_nettype none
module nearest_target_pursuit_top_test;
  import ntp_pkg::*;

  // one enemy entry as offered on the input channel
  typedef struct {
    logic [COORD_W-1:0] own_x;
    logic [COORD_W-1:0] own_y;
    logic [COOL_W-1:0]  own_cooldown;
    logic [COORD_W-1:0] enemy_x;
    logic [COORD_W-1:0] enemy_y;
    logic               enemy_alive;
    logic               last_enemy;
  } entry_word_t;

  // one decision as produced on the result channel
  typedef struct {
    logic signed [VEL_W-1:0] velocity_x;
    logic signed [VEL_W-1:0] velocity_y;
    logic                    target_valid;
    logic                    nearest_found;
    logic [INDEX_W-1:0]      nearest_index;
    logic [DIST_W-1:0]       nearest_distance;
    logic [COORD_W-1:0]      echo_x;
    logic [COORD_W-1:0]      echo_y;
  } decision_word_t;

  // nearest-enemy search mirror plus the queue of decisions still owed
  class pursuit_checker;
    logic [SPEED_W-1:0] max_speed;
    logic [RANGE_W-1:0] engage_range;
    int unsigned        entry_count;
    logic [INDEX_W-1:0] best_index;
    logic [D2_W-1:0]    best_d2;
    bit                 best_found;
    int                 best_dx;
    int                 best_dy;
    decision_word_t     decisions_due[$];
    int                 errors;

    function new();
      max_speed    = '0;
      engage_range = '0;
      errors       = 0;
      clear_search();
    endfunction

    function void clear_search();
      entry_count = 0;
      best_index  = '0;
      best_d2     = '1;
      best_found  = 0;
      best_dx     = 0;
      best_dy     = 0;
    endfunction

    function int pending();
      return decisions_due.size();
    endfunction

    // floor square root, one result bit per trial from the top down
    function logic [DIST_W-1:0] floor_root(logic [D2_W-1:0] v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root[DIST_W-1:0];
    endfunction

    // offset times speed over distance, truncated toward zero
    function logic [VEL_W-1:0] pursuit_speed(int d, logic [DIST_W-1:0] span);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? longint'(-d) : longint'(d);
      q   = (mag * max_speed) / span;
      if (d < 0) q = -q;
      return q[VEL_W-1:0];
    endfunction

    function void take_entry(entry_word_t w);
      int              dx;
      int              dy;
      longint unsigned d2;
      decision_word_t  dec;
      logic [DIST_W-1:0] span;
      // search: surplus entries past the table size are dropped
      if (entry_count < MAX_ENEMIES) begin
        if (w.enemy_alive) begin
          dx = int'(w.enemy_x) - int'(w.own_x);
          dy = int'(w.enemy_y) - int'(w.own_y);
          d2 = longint'(dx) * dx + longint'(dy) * dy;
          if (!best_found || d2 < best_d2) begin
            best_found = 1;
            best_d2    = d2[D2_W-1:0];
            best_index = entry_count[INDEX_W-1:0];
            best_dx    = dx;
            best_dy    = dy;
          end
        end
        entry_count++;
      end
      if (!w.last_enemy) return;
      // close the decision
      dec.echo_x = w.own_x;
      dec.echo_y = w.own_y;
      if (best_found) begin
        span = floor_root(best_d2);
        dec.velocity_x       = (span != 0) ? pursuit_speed(best_dx, span) : '0;
        dec.velocity_y       = (span != 0) ? pursuit_speed(best_dy, span) : '0;
        dec.target_valid     = (span <= engage_range) && (w.own_cooldown == 0);
        dec.nearest_found    = 1'b1;
        dec.nearest_index    = best_index;
        dec.nearest_distance = span;
      end else begin
        dec.velocity_x       = '0;
        dec.velocity_y       = '0;
        dec.target_valid     = 1'b0;
        dec.nearest_found    = 1'b0;
        dec.nearest_index    = '0;
        dec.nearest_distance = '1;
      end
      decisions_due.push_back(dec);
      clear_search();
    endfunction

    function void match(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function void check_decision(decision_word_t r);
      decision_word_t e;
      if (decisions_due.size() == 0) begin
        $error("decision word with none outstanding");
        errors++;
        return;
      end
      e = decisions_due.pop_front();
      match("velocity_x", e.velocity_x, r.velocity_x);
      match("velocity_y", e.velocity_y, r.velocity_y);
      match("target_valid", e.target_valid, r.target_valid);
      match("nearest_found", e.nearest_found, r.nearest_found);
      match("nearest_index", e.nearest_index, r.nearest_index);
      match("nearest_distance", e.nearest_distance, r.nearest_distance);
      match("echo_x", e.echo_x, r.echo_x);
      match("echo_y", e.echo_y, r.echo_y);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  wire  [APB_DW-1:0] prdata;
  wire               pready;

  ntp_in_if  enemy_ch();
  ntp_out_if result_ch();

  nearest_target_pursuit_top u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .enemy   (enemy_ch),
    .result  (result_ch)
  );

  pursuit_checker board = new();
  int send_idle_pct;
  int recv_idle_pct;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // overall time limit
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result sink back-pressure
  always @(posedge clk) begin
    if (rst) result_ch.ready <= 1'b0;
    else     result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watch both channels; entries are noted before results are checked
  always @(posedge clk) begin
    entry_word_t    ew;
    decision_word_t dw;
    if (!rst) begin
      if (enemy_ch.valid && enemy_ch.ready) begin
        ew.own_x        = enemy_ch.own_x;
        ew.own_y        = enemy_ch.own_y;
        ew.own_cooldown = enemy_ch.own_cooldown;
        ew.enemy_x      = enemy_ch.enemy_x;
        ew.enemy_y      = enemy_ch.enemy_y;
        ew.enemy_alive  = enemy_ch.enemy_alive;
        ew.last_enemy   = enemy_ch.last_enemy;
        board.take_entry(ew);
      end
      if (result_ch.valid && result_ch.ready) begin
        dw.velocity_x       = result_ch.velocity_x;
        dw.velocity_y       = result_ch.velocity_y;
        dw.target_valid     = result_ch.target_valid;
        dw.nearest_found    = result_ch.nearest_found;
        dw.nearest_index    = result_ch.nearest_index;
        dw.nearest_distance = result_ch.nearest_distance;
        dw.echo_x           = result_ch.echo_x;
        dw.echo_y           = result_ch.echo_y;
        board.check_decision(dw);
      end
    end
  end

  // register write: setup then access phase
  task automatic write_reg(logic [0:0] sel, logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_MAX_SPEED) board.max_speed    = value[SPEED_W-1:0];
    else                      board.engage_range = value[RANGE_W-1:0];
  endtask

  task automatic set_limits(logic [SPEED_W-1:0] speed, logic [RANGE_W-1:0] range);
    write_reg(REG_MAX_SPEED, APB_DW'(speed));
    write_reg(REG_ENGAGE_RANGE, APB_DW'(range));
  endtask

  // drain outstanding decisions, then let the datapath settle
  task automatic drain();
    enemy_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // offer one word, with random gaps in front of it
  task automatic send_entry(entry_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      enemy_ch.valid <= 1'b0;
      @(posedge clk);
    end
    enemy_ch.valid        <= 1'b1;
    enemy_ch.own_x        <= w.own_x;
    enemy_ch.own_y        <= w.own_y;
    enemy_ch.own_cooldown <= w.own_cooldown;
    enemy_ch.enemy_x      <= w.enemy_x;
    enemy_ch.enemy_y      <= w.enemy_y;
    enemy_ch.enemy_alive  <= w.enemy_alive;
    enemy_ch.last_enemy   <= w.last_enemy;
    do @(posedge clk); while (!enemy_ch.ready);
  endtask

  task automatic send_fields(int ox, int oy, int cool, int ex, int ey, bit alive, bit last);
    entry_word_t w;
    w.own_x        = ox[COORD_W-1:0];
    w.own_y        = oy[COORD_W-1:0];
    w.own_cooldown = cool[COOL_W-1:0];
    w.enemy_x      = ex[COORD_W-1:0];
    w.enemy_y      = ey[COORD_W-1:0];
    w.enemy_alive  = alive;
    w.last_enemy   = last;
    send_entry(w);
  endtask

  // one random decision; returns the number of words sent
  task automatic random_decision(output int len);
    int                 pick;
    bit                 moving;
    bit                 all_dead;
    bit                 clustered;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    entry_word_t        w;
    pick = $urandom_range(99);
    if (pick < 3)       len = $urandom_range(60, 72);
    else if (pick < 12) len = 1;
    else                len = $urandom_range(2, 8);
    ox        = COORD_W'($urandom);
    oy        = COORD_W'($urandom);
    px        = COORD_W'($urandom);
    py        = COORD_W'($urandom);
    moving    = ($urandom_range(9) == 0);
    all_dead  = ($urandom_range(11) == 0);
    clustered = ($urandom_range(1) == 1);
    w.own_cooldown = $urandom_range(1) ? '0 : COOL_W'($urandom_range(1, 255));
    for (int i = 0; i < len; i++) begin
      if (moving) begin
        ox = COORD_W'($urandom);
        oy = COORD_W'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        // same spot as the previous entry: a tie
        w.enemy_x = px;
        w.enemy_y = py;
      end else if (pick < 18) begin
        w.enemy_x = ox;
        w.enemy_y = oy;
      end else if (pick < 28) begin
        w.enemy_x = $urandom_range(1) ? '1 : '0;
        w.enemy_y = $urandom_range(1) ? '1 : '0;
      end else if (pick < 60 && clustered) begin
        w.enemy_x = ox + COORD_W'($urandom_range(511)) - COORD_W'(256);
        w.enemy_y = oy + COORD_W'($urandom_range(511)) - COORD_W'(256);
      end else begin
        w.enemy_x = COORD_W'($urandom);
        w.enemy_y = COORD_W'($urandom);
      end
      w.own_x       = ox;
      w.own_y       = oy;
      w.enemy_alive = !all_dead && ($urandom_range(3) != 0);
      w.last_enemy  = (i == len - 1);
      send_entry(w);
      px = w.enemy_x;
      py = w.enemy_y;
    end
  endtask

  // stimulus
  initial begin
    logic [SPEED_W-1:0] speeds[6];
    logic [RANGE_W-1:0] ranges[6];
    int                 sent;
    int                 len;
    speeds = '{16'd64, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF};
    ranges = '{17'd6400, 17'h1FFFF, 17'd0, 17'd0, 17'd0, 17'd0};
    speeds[3] = SPEED_W'($urandom);
    speeds[4] = SPEED_W'($urandom);
    ranges[3] = RANGE_W'($urandom_range(131071));
    ranges[4] = RANGE_W'($urandom_range(4095));
    send_idle_pct          <= 0;
    recv_idle_pct          <= 0;
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    enemy_ch.valid         <= 1'b0;
    enemy_ch.own_x         <= '0;
    enemy_ch.own_y         <= '0;
    enemy_ch.own_cooldown  <= '0;
    enemy_ch.enemy_x       <= '0;
    enemy_ch.enemy_y       <= '0;
    enemy_ch.enemy_alive   <= 1'b0;
    enemy_ch.last_enemy    <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed decisions
    set_limits(16'd1000, 17'd5000);
    // nothing alive
    send_fields(100, 200, 0, 300, 400, 0, 1);
    // enemy on top of us, ready to fire
    send_fields(4000, 4000, 0, 4000, 4000, 1, 1);
    // opposite corners, both directions
    send_fields(0, 0, 255, 65535, 65535, 1, 1);
    send_fields(65535, 65535, 0, 0, 0, 1, 1);
    // equal distances keep the earlier index; dead entry closes
    send_fields(1000, 1000, 0, 997, 1004, 1, 0);
    send_fields(1000, 1000, 0, 1004, 997, 1, 0);
    send_fields(1000, 1000, 0, 1000, 1000, 0, 1);
    // own position moving within one decision
    send_fields(100, 100, 7, 110, 100, 1, 0);
    send_fields(5000, 5000, 0, 5000, 5020, 1, 1);
    // later entry closer, pure x then pure y offsets
    send_fields(30000, 30000, 0, 30000, 32000, 1, 0);
    send_fields(30000, 30000, 0, 29000, 30000, 1, 0);
    send_fields(30000, 30000, 0, 30000, 29990, 1, 1);
    // in range but cooling down
    send_fields(500, 500, 1, 600, 500, 1, 1);
    drain();

    // random phases: receiver-heavy gaps, sender-heavy gaps, none
    for (int p = 0; p < 6; p++) begin
      set_limits(speeds[p], ranges[p]);
      send_idle_pct <= (p < 2) ? 33 : (p < 4) ? 64 : 0;
      recv_idle_pct <= (p < 2) ? 64 : (p < 4) ? 33 : 0;
      sent = 0;
      while (sent < 215) begin
        random_decision(len);
        sent += len;
      end
      drain();
    end

    // wrap-up
    while (board.pending() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
